### hdl/bca_pkg.sv
package bca_pkg;

    // Pool geometry
    localparam int MAX_CHUNKS = 1024;
    localparam int WORD_BITS  = 64;
    localparam int NWORDS     = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_W     = $clog2(NWORDS);
    localparam int WCNT_W     = $clog2(NWORDS + 1);

    // Field widths
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int BYTES_W = 17;
    localparam int OFS_W   = 26;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_CHUNK_BYTES = 65536;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]   CHUNK_COUNT_RST = CNT_W'(1024);
    localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = BYTES_W'(64);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_MUL,
        ST_DONE
    } t_state;

    // Update command into the bitmap store
    typedef struct packed {
        logic              clear_all;
        logic              set_bit;
        logic              clr_bit;
        logic [WORD_W-1:0] word;
        logic [BIT_W-1:0]  bit_pos;
    } t_bm_cmd;

endpackage

### hdl/bca_bitmap.sv
module bca_bitmap
    import bca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_bm_cmd              i_cmd,
    input  logic [WORD_W-1:0]    i_rd_word,
    output logic [WORD_BITS-1:0] o_rd_data
);

    // One bit per chunk, set while the chunk is in use
    logic [WORD_BITS-1:0] r_words [NWORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            for (int i = 0; i < NWORDS; i++) begin
                r_words[i] <= '0;
            end
        end else if (i_cmd.set_bit) begin
            r_words[i_cmd.word][i_cmd.bit_pos] <= 1'b1;
        end else if (i_cmd.clr_bit) begin
            r_words[i_cmd.word][i_cmd.bit_pos] <= 1'b0;
        end
    end

    assign o_rd_data = r_words[i_rd_word];

endmodule

### hdl/bca_free_find.sv
module bca_free_find
    import bca_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_last,
    input  logic [BIT_W-1:0]     i_rem,
    output logic                 o_found,
    output logic [BIT_W-1:0]     o_bit_pos
);

    logic [WORD_BITS-1:0] open_bits;

    // Free bits of the word, with chunks past the pool end masked off
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            open_bits[b] = !i_word[b] &&
                (!i_last || (i_rem == '0) || (BIT_W'(b) < i_rem));
        end
    end

    // Lowest free bit
    always_comb begin
        o_bit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (open_bits[b]) begin
                o_bit_pos = BIT_W'(b);
            end
        end
    end

    assign o_found = |open_bits;

endmodule

### hdl/bca_offset_mul.sv
module bca_offset_mul
    import bca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [BYTES_W-1:0] i_bytes,
    output logic [OFS_W-1:0]   o_offset
);

    logic [IDX_W+BYTES_W-1:0] product;
    logic [OFS_W-1:0]         r_offset;

    assign product = i_index * i_bytes;

    // Registered product, truncated to the offset width
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_offset <= product[OFS_W-1:0];
        end
    end

    assign o_offset = r_offset;

endmodule

### hdl/bitmap_chunk_allocator.sv
// Next-fit allocator of fixed-size chunks over a bitmap of 64-bit words. Acquire
// (op 0) scans the words one per cycle from the hint word (the word of the last
// grant, or of a lower released chunk), wrapping at the pool end, and takes the
// lowest free chunk of the first word that has one; release (op 1) frees a chunk
// in use; lookup (op 2) returns index times chunk size for a chunk in use. One
// result word follows every input word. Release goes from the execute state to
// the done state, lookup also passes the registered offset multiplier, and
// acquire scans up to 16 bitmap words and, on a grant, also uses the multiplier;
// there is a single word-scan unit and a single offset multiplier. The block
// takes no input word while an operation is in flight or while a configuration
// write is offered. Writing either configuration register clears the whole pool
// in that cycle; writes are taken only while no operation is in flight.
module bitmap_chunk_allocator
    import bca_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Operation channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [IDX_W-1:0]      i_chunk_index,
    // Result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_ok,
    output logic [IDX_W-1:0]      o_granted_index,
    output logic [OFS_W-1:0]      o_byte_offset,
    output logic [CNT_W-1:0]      o_free_chunks,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [CNT_W-1:0]   r_free, n_free;
    logic [WORD_W-1:0]  r_start, n_start;
    logic [WORD_W-1:0]  r_w, n_w;
    logic [WCNT_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;

    // Item and result staging
    logic [OP_W-1:0]    r_op, n_op;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_res_ok, n_res_ok;
    logic [IDX_W-1:0]   r_res_idx, n_res_idx;
    logic               r_use_ofs, n_use_ofs;

    // Output word
    logic               r_ok, n_ok;
    logic [IDX_W-1:0]   r_granted, n_granted;
    logic [OFS_W-1:0]   r_ofs, n_ofs;
    logic [CNT_W-1:0]   r_free_out, n_free_out;

    t_bm_cmd              bm_cmd;
    logic [WORD_W-1:0]    rd_word;
    logic [WORD_BITS-1:0] rd_data;
    logic                 scan_found;
    logic [BIT_W-1:0]     scan_bit;
    logic                 mul_en;
    logic [OFS_W-1:0]     mul_ofs;

    logic [CNT_W:0]       count_round;
    logic [WCNT_W-1:0]    words;
    logic [WCNT_W-1:0]    last_word;
    logic                 at_last;
    logic                 idx_in_use;
    logic                 cfg_fire;
    logic [CNT_W-1:0]     cfg_count;
    logic [BYTES_W-1:0]   cfg_bytes;

    // Pool geometry from the chunk count
    assign count_round = {1'b0, r_count} + (CNT_W + 1)'(WORD_BITS - 1);
    assign words       = WCNT_W'(count_round >> BIT_W);
    assign last_word   = words - WCNT_W'(1);
    assign at_last     = ({{(WCNT_W - WORD_W){1'b0}}, r_w} == last_word);

    // Bitmap read: scan pointer while searching, else the item's word
    assign rd_word    = (r_state == ST_SCAN) ? r_w : r_idx[IDX_W-1:BIT_W];
    assign idx_in_use = ({1'b0, r_idx} < r_count) && rd_data[r_idx[BIT_W-1:0]];

    // Saturated configuration values
    assign cfg_count = (i_cfg_data[CNT_W-1:0] > CNT_W'(MAX_CHUNKS)) ?
                       CNT_W'(MAX_CHUNKS) : i_cfg_data[CNT_W-1:0];
    assign cfg_bytes = (i_cfg_data[BYTES_W-1:0] > BYTES_W'(MAX_CHUNK_BYTES)) ?
                       BYTES_W'(MAX_CHUNK_BYTES) : i_cfg_data[BYTES_W-1:0];

    // A configuration write wins over an input word in the same cycle
    assign o_stall     = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    bca_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (bm_cmd),
        .i_rd_word (rd_word),
        .o_rd_data (rd_data)
    );

    bca_free_find u_find (
        .i_word    (rd_data),
        .i_last    (at_last),
        .i_rem     (r_count[BIT_W-1:0]),
        .o_found   (scan_found),
        .o_bit_pos (scan_bit)
    );

    bca_offset_mul u_mul (
        .i_clk    (i_clk),
        .i_en     (mul_en),
        .i_index  (r_res_idx),
        .i_bytes  (r_bytes),
        .o_offset (mul_ofs)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_free      = r_free;
        n_start     = r_start;
        n_w         = r_w;
        n_step      = r_step;
        n_op        = r_op;
        n_idx       = r_idx;
        n_res_ok    = r_res_ok;
        n_res_idx   = r_res_idx;
        n_use_ofs   = r_use_ofs;
        n_ok        = r_ok;
        n_granted   = r_granted;
        n_ofs       = r_ofs;
        n_free_out  = r_free_out;
        n_out_valid = r_out_valid;
        bm_cmd      = '0;
        mul_en      = 1'b0;

        // Result word taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (cfg_fire) begin
                    case (i_cfg_index)
                        CFG_CHUNK_COUNT: begin
                            n_count = cfg_count;
                            n_free  = cfg_count;
                        end
                        CFG_CHUNK_BYTES: begin
                            n_bytes = cfg_bytes;
                            n_free  = r_count;
                        end
                        default: ;
                    endcase
                    n_start          = '0;
                    bm_cmd.clear_all = 1'b1;
                end else if (i_valid) begin
                    n_op    = i_op;
                    n_idx   = i_chunk_index;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_res_ok  = 1'b0;
                n_res_idx = r_idx;
                n_use_ofs = 1'b0;
                n_state   = ST_DONE;
                case (r_op)
                    OP_ACQUIRE: begin
                        if ((r_free != '0) && (words != '0)) begin
                            n_w     = r_start;
                            n_step  = '0;
                            n_state = ST_SCAN;
                        end
                    end
                    OP_RELEASE: begin
                        if (idx_in_use) begin
                            bm_cmd.clr_bit = 1'b1;
                            bm_cmd.word    = r_idx[IDX_W-1:BIT_W];
                            bm_cmd.bit_pos = r_idx[BIT_W-1:0];
                            n_free         = r_free + CNT_W'(1);
                            if (r_idx[IDX_W-1:BIT_W] < r_start) begin
                                n_start = r_idx[IDX_W-1:BIT_W];
                            end
                            n_res_ok = 1'b1;
                        end
                    end
                    OP_LOOKUP: begin
                        if (idx_in_use) begin
                            n_res_ok  = 1'b1;
                            n_use_ofs = 1'b1;
                            n_state   = ST_MUL;
                        end
                    end
                    default: ;
                endcase
            end

            // One bitmap word per cycle from the hint, wrapping at the pool end
            ST_SCAN: begin
                if (scan_found) begin
                    bm_cmd.set_bit = 1'b1;
                    bm_cmd.word    = r_w;
                    bm_cmd.bit_pos = scan_bit;
                    n_free         = r_free - CNT_W'(1);
                    n_start        = r_w;
                    n_res_ok       = 1'b1;
                    n_res_idx      = IDX_W'({r_w, scan_bit});
                    n_use_ofs      = 1'b1;
                    n_state        = ST_MUL;
                end else if (r_step == last_word) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + WCNT_W'(1);
                    n_w    = at_last ? '0 : r_w + WORD_W'(1);
                end
            end

            ST_MUL: begin
                mul_en  = 1'b1;
                n_state = ST_DONE;
            end

            // Load the output word once the slot is free
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_ok        = r_res_ok;
                    n_granted   = r_res_idx;
                    n_ofs       = r_use_ofs ? mul_ofs : '0;
                    n_free_out  = r_free;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= CHUNK_COUNT_RST;
            r_bytes     <= CHUNK_BYTES_RST;
            r_free      <= CHUNK_COUNT_RST;
            r_start     <= '0;
            r_w         <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_free      <= n_free;
            r_start     <= n_start;
            r_w         <= n_w;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_res_ok   <= n_res_ok;
        r_res_idx  <= n_res_idx;
        r_use_ofs  <= n_use_ofs;
        r_ok       <= n_ok;
        r_granted  <= n_granted;
        r_ofs      <= n_ofs;
        r_free_out <= n_free_out;
    end

    assign o_valid         = r_out_valid;
    assign o_ok            = r_ok;
    assign o_granted_index = r_granted;
    assign o_byte_offset   = r_ofs;
    assign o_free_chunks   = r_free_out;

endmodule

### sim/bitmap_chunk_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_chunk_allocator_test
    import bca_pkg::*;
();

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MODE_CYCLES    = 400;
    localparam int NUM_PHASES     = 8;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
    } t_alloc_req;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] granted;
        logic [OFS_W-1:0] offset;
        logic [CNT_W-1:0] free;
    } t_alloc_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OP_W-1:0]       i_op;
    logic [IDX_W-1:0]      i_chunk_index;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_ok;
    logic [IDX_W-1:0]      o_granted_index;
    logic [OFS_W-1:0]      o_byte_offset;
    logic [CNT_W-1:0]      o_free_chunks;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Request words waiting for the driver, results waiting for the DUT
    t_alloc_req    pending_reqs[$];
    t_alloc_result expected_results[$];

    // Allocator shadow state
    logic [WORD_BITS-1:0] alloc_map [NWORDS];
    int unsigned          free_left;
    int unsigned          hint_word;
    int unsigned          count_reg;
    int unsigned          bytes_reg;

    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned cycle_count;
    bit          req_taken;

    bitmap_chunk_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_chunk_index   (i_chunk_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_ok            (o_ok),
        .o_granted_index (o_granted_index),
        .o_byte_offset   (o_byte_offset),
        .o_free_chunks   (o_free_chunks),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned pool_size();
        return (count_reg > MAX_CHUNKS) ? MAX_CHUNKS : count_reg;
    endfunction

    function automatic logic [OFS_W-1:0] offset_of(input int unsigned idx);
        longint unsigned a;
        longint unsigned sz;
        longint unsigned prod;
        a    = idx;
        sz   = (bytes_reg > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : bytes_reg;
        prod = a * sz;
        return prod[OFS_W-1:0];
    endfunction

    function automatic void clear_pool();
        foreach (alloc_map[i]) alloc_map[i] = '0;
        free_left = pool_size();
        hint_word = 0;
    endfunction

    // Register write: any write empties the pool
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] sel,
                                            input logic [CFG_DATA_W-1:0] data);
        if (sel == CFG_CHUNK_COUNT) begin
            count_reg = data[CNT_W-1:0];
        end else begin
            count_reg = count_reg;
            bytes_reg = data[BYTES_W-1:0];
        end
        clear_pool();
    endfunction

    // Next-fit allocation: scan from the hint word, lowest free bit wins
    function automatic t_alloc_result predict_op(input logic [OP_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx);
        t_alloc_result    r;
        int unsigned      n;
        int unsigned      words;
        int unsigned      w;
        int unsigned      rem;
        int unsigned      s;
        int unsigned      b;
        logic [WORD_BITS-1:0] avail;
        bit               found;
        n         = pool_size();
        r.ok      = 1'b0;
        r.granted = idx;
        r.offset  = '0;
        found     = 0;
        case (op)
            OP_ACQUIRE: begin
                words = (n + WORD_BITS - 1) / WORD_BITS;
                rem   = n % WORD_BITS;
                if (free_left != 0 && words != 0) begin
                    for (s = 0; s < words && !found; s++) begin
                        w     = (hint_word + s) % words;
                        avail = ~alloc_map[w];
                        // bits past the pool end are never free
                        if (w == words - 1 && rem != 0)
                            avail &= (WORD_BITS'(1) << rem) - WORD_BITS'(1);
                        for (b = 0; b < WORD_BITS && !found; b++) begin
                            if (avail[b]) begin
                                alloc_map[w][b] = 1'b1;
                                free_left--;
                                hint_word = w;
                                r.granted = IDX_W'(w * WORD_BITS + b);
                                r.offset  = offset_of(w * WORD_BITS + b);
                                r.ok      = 1'b1;
                                found     = 1;
                            end
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (idx < n && alloc_map[idx / WORD_BITS][idx % WORD_BITS]) begin
                    alloc_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                    free_left++;
                    if (idx / WORD_BITS < hint_word) hint_word = idx / WORD_BITS;
                    r.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (idx < n && alloc_map[idx / WORD_BITS][idx % WORD_BITS]) begin
                    r.offset = offset_of(idx);
                    r.ok     = 1'b1;
                end
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        r.free = CNT_W'(free_left);
        return r;
    endfunction

    // Driver: presents request words at the falling edge, random gaps and stalls
    always @(negedge i_clk) begin : req_driver
        int unsigned traffic_mode;
        int unsigned idle_pct;
        int unsigned stall_pct;
        traffic_mode = (cycle_count / MODE_CYCLES) % 5;
        case (traffic_mode)
            1:       begin idle_pct = 64; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 64; end
            3:       begin idle_pct = 20; stall_pct = 20; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            // a word still waiting stays on the bus unchanged
            if (!(i_valid && !req_taken)) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid       <= 1'b1;
                    i_op          <= pending_reqs[0].op;
                    i_chunk_index <= pending_reqs[0].idx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
        req_taken = 0;
    end

    // Monitor: predicts on accept, checks results, watches for a hang
    always @(posedge i_clk) begin : result_check
        t_alloc_result got;
        t_alloc_result want;
        bit            progress;
        cycle_count++;
        progress = 0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
                progress = 1;
            end
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_op(i_op, i_chunk_index));
                void'(pending_reqs.pop_front());
                req_taken = 1;
                progress  = 1;
            end
            if (o_valid && !i_stall) begin
                progress = 1;
                got = '{o_ok, o_granted_index, o_byte_offset, o_free_chunks};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result word with nothing expected: ok=%0d idx=%0d",
                                 $time, got.ok, got.granted);
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok != want.ok || got.granted != want.granted ||
                        got.offset != want.offset || got.free != want.free) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch expected ok=%0d idx=%0d ofs=%0d ",
                                      "free=%0d, got ok=%0d idx=%0d ofs=%0d free=%0d"},
                                     $time, want.ok, want.granted, want.offset, want.free,
                                     got.ok, got.granted, got.offset, got.free);
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [OP_W-1:0] op, input int unsigned idx);
        pending_reqs.push_back(t_alloc_req'{op, IDX_W'(idx)});
    endtask

    // Wait until every queued word has gone through and been checked
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input int unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Count register: junk in the unused upper data bits
    task automatic write_count(input int unsigned cnt);
        write_reg(CFG_CHUNK_COUNT, ($urandom_range(63) << CNT_W) | cnt);
    endtask

    initial begin : stimulus
        int unsigned phase_count [NUM_PHASES] = '{65, 1, 64, 63, 0, 127, 1500, 300};
        int unsigned phase_bytes [NUM_PHASES] = '{3, 1, 65536, 131071, 0, 0, 0, 0};
        int unsigned phase_items [NUM_PHASES] = '{60, 30, 50, 50, 15, 50, 40, 50};
        int unsigned phase_acq   [NUM_PHASES] = '{60, 40, 55, 55, 40, 50, 50, 50};
        int unsigned lim;
        int unsigned held_est;
        int unsigned roll;
        int unsigned idx;
        int unsigned acquired;
        logic [OP_W-1:0] op;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_op          = OP_ACQUIRE;
        i_chunk_index = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_CHUNK_COUNT;
        i_cfg_data    = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        cycle_count    = 0;
        req_taken      = 0;
        count_reg      = CHUNK_COUNT_RST;
        bytes_reg      = CHUNK_BYTES_RST;
        clear_pool();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pool: failures on a free chunk, unused op, basic grants and frees
        push_req(OP_LOOKUP, 0);
        push_req(OP_RELEASE, 1023);
        push_req(OP_UNUSED, 1023);
        push_req(OP_ACQUIRE, 1023);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_LOOKUP, 2);
        push_req(OP_RELEASE, 1);
        push_req(OP_RELEASE, 1);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_UNUSED, 0);
        drain();

        // Empty pool: everything fails
        write_count(0);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_RELEASE, 0);
        push_req(OP_LOOKUP, 0);
        drain();

        // Oversized count saturates, zero chunk size gives zero offsets
        write_count(2047);
        write_reg(CFG_CHUNK_BYTES, 0);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_LOOKUP, 0);
        drain();

        // Single-chunk pool with oversized chunk size: full pool, out of range
        write_count(1);
        write_reg(CFG_CHUNK_BYTES, 131071);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_LOOKUP, 0);
        push_req(OP_RELEASE, 1);
        push_req(OP_RELEASE, 0);
        push_req(OP_ACQUIRE, 0);
        drain();

        // Random mixes over a spread of pool shapes
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_count(phase_count[p]);
            write_reg(CFG_CHUNK_BYTES,
                      (p >= 5) ? $urandom_range(131071) : phase_bytes[p]);
            lim      = (phase_count[p] > MAX_CHUNKS) ? MAX_CHUNKS : phase_count[p];
            held_est = 0;
            for (int k = 0; k < phase_items[p]; k++) begin
                roll = $urandom_range(99);
                if (roll < phase_acq[p]) begin
                    push_req(OP_ACQUIRE, $urandom_range(1023));
                    if (held_est < lim) held_est++;
                end else if (roll >= 95) begin
                    push_req(OP_UNUSED, $urandom_range(1023));
                end else begin
                    op = $urandom_range(1) ? OP_RELEASE : OP_LOOKUP;
                    // mostly chunks likely held, the rest anywhere
                    if (held_est != 0 && $urandom_range(9) < 7)
                        idx = $urandom_range(held_est - 1);
                    else
                        idx = $urandom_range(1023);
                    push_req(op, idx);
                end
            end
            drain();
        end

        // Fill the largest pool with the largest chunk size to reach the top offset
        write_count(1024);
        write_reg(CFG_CHUNK_BYTES, 65536);
        acquired = 0;
        while (acquired < MAX_CHUNKS + 2) begin
            push_req(OP_ACQUIRE, $urandom_range(1023));
            acquired++;
            roll = $urandom_range(99);
            if (roll < 5) begin
                push_req(OP_LOOKUP, $urandom_range(acquired - 1));
            end else if (roll == 5) begin
                push_req(OP_RELEASE, $urandom_range(acquired - 1));
                acquired--;
            end
        end
        push_req(OP_LOOKUP, 1023);
        push_req(OP_RELEASE, 1023);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_ACQUIRE, 0);
        push_req(OP_RELEASE, 0);
        push_req(OP_LOOKUP, 0);
        push_req(OP_ACQUIRE, 0);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
